// ===== sv/gsp_pkg.sv =====
// Shared types, register map and constant tables for the gas sensor ppm converter.
package gsp_pkg;

    // Fixed field widths
    localparam int ADC_W      = 12;
    localparam int UPTIME_W   = 32;
    localparam int PPM_W      = 20;
    localparam int LOG_IN_W   = 24;   // widest operand of the log unit (curve_scale)
    localparam int LOG_W      = 21;   // unsigned log2 result, Q5.16
    localparam int LOG0_W     = 24;   // stored clean-air log, signed Q8.16
    localparam int FRAC_W     = 16;
    localparam int MANT_W     = 31;   // normalised mantissa, Q1.30
    localparam int DIV_STEPS  = 36;
    localparam int SQ_STEPS   = 16;

    localparam logic [PPM_W-1:0]    PPM_MAX   = '1;
    localparam logic [LOG_IN_W-1:0] CAL_PPM   = 24'd20;
    localparam logic [2:0]          LOAD_RES  = 3'd5;
    localparam logic signed [21:0]  SCALE_OFS = 22'sd524288;   // 8.0 in Q.16
    localparam logic signed [37:0]  LOG0_MAX  = 38'sd8388607;
    localparam logic signed [37:0]  LOG0_MIN  = -38'sd8388608;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_CAL_WINDOW = 2'd0,
        REG_SCALE      = 2'd1,
        REG_EXPONENT   = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]        cal_window_ms;
        logic [23:0]        curve_scale;
        logic signed [15:0] curve_exponent;
    } cfg_t;

    typedef struct packed {
        logic [ADC_W-1:0]    adc_sample;
        logic [UPTIME_W-1:0] uptime_ms;
    } in_item_t;

    typedef struct packed {
        logic [PPM_W-1:0] ppm;
        logic             saturated;
        logic             calibrating;
        logic             calibrated;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_DIV,
        ST_LP,
        ST_EXP,
        ST_ROUND,
        ST_DONE
    } state_t;

    // Integer square root, elaboration-time use only
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-(k+1)) in Q1.30 by repeated square roots, elaboration-time use only
    function automatic logic [31:0] exp2_factor(input int k);
        logic [63:0] c;
        c = 64'd2 << 30;
        for (int j = 0; j <= k; j++) c = isqrt64(c << 30);
        return c[31:0];
    endfunction

    localparam logic [31:0] EXP_C [SQ_STEPS] = '{
        exp2_factor(0),  exp2_factor(1),  exp2_factor(2),  exp2_factor(3),
        exp2_factor(4),  exp2_factor(5),  exp2_factor(6),  exp2_factor(7),
        exp2_factor(8),  exp2_factor(9),  exp2_factor(10), exp2_factor(11),
        exp2_factor(12), exp2_factor(13), exp2_factor(14), exp2_factor(15)
    };

endpackage

// ===== sv/gas_sensor_ppm_converter.sv =====
// Top level: configuration registers, input handshake and output register.
//
//   channel   direction  handshake            payload
//   in        in         in_valid / in_stall  gsp_pkg::in_item_t
//   out       out        out_valid / out_stall gsp_pkg::out_item_t
//   apb       in/out     psel, penable        paddr, pwdata, prdata
//
// A transaction reaches the output register after four log2 evaluations, a shift-subtract
// divide when it recalibrates, a power-law step, 16 exp2 steps, a rounding step and a
// hand-over state; the log2, power-law and exp2 steps share one 33x33 multiplier. With no
// power law, or with one out of range, it goes straight to the hand-over state.
// in_stall is high until the result is in the output register, so the next sample is
// taken only after that. Reset restores default configuration and forgets the clean-air
// resistance. A stalled result holds while the next sample is worked.
module gas_sensor_ppm_converter #(
    parameter int ADC_BITS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  gsp_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output gsp_pkg::out_item_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    gsp_pkg::cfg_t      cfg_reg, cfg_next;
    logic               out_valid_reg, out_valid_next;
    gsp_pkg::out_item_t out_data_reg, out_data_next;
    logic               core_busy;
    logic               res_valid;
    logic               res_take;
    gsp_pkg::out_item_t res_data;
    gsp_pkg::reg_idx_t  reg_idx;

    // Register writes and reads
    always_comb
    begin
        reg_idx  = gsp_pkg::reg_idx_t'(paddr[3:2]);
        pready   = 1'b1;
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (reg_idx)
                gsp_pkg::REG_CAL_WINDOW: cfg_next.cal_window_ms  = pwdata[15:0];
                gsp_pkg::REG_SCALE:      cfg_next.curve_scale    = pwdata[23:0];
                gsp_pkg::REG_EXPONENT:   cfg_next.curve_exponent = $signed(pwdata[15:0]);
                default:
                begin
                end
            endcase
        end
        case (reg_idx)
            gsp_pkg::REG_CAL_WINDOW: prdata = {16'd0, cfg_reg.cal_window_ms};
            gsp_pkg::REG_SCALE:      prdata = {8'd0, cfg_reg.curve_scale};
            gsp_pkg::REG_EXPONENT:   prdata = {16'd0, cfg_reg.curve_exponent};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_window_ms  <= 16'd3000;
            cfg_reg.curve_scale    <= 24'd157158;
            cfg_reg.curve_exponent <= -16'sd8495;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer and datapath
    gsp_core #(
        .ADC_BITS (ADC_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && !in_stall),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .busy      (core_busy),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_data  (res_data)
    );

    // Output register
    always_comb
    begin
        in_stall       = core_busy;
        res_take       = res_valid && (!out_valid_reg || !out_stall);
        out_data_next  = res_take ? res_data : out_data_reg;
        if (res_take)       out_valid_next = 1'b1;
        else if (out_stall) out_valid_next = out_valid_reg;
        else                out_valid_next = 1'b0;
        out_valid      = out_valid_reg;
        out_data       = out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else        out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ===== sv/gsp_core.sv =====
// Sequencer and shared multiplier datapath: log2, calibration divide, power law, exp2.
module gsp_core #(
    parameter int ADC_BITS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  gsp_pkg::in_item_t in_data,
    input  gsp_pkg::cfg_t     cfg,
    output logic              busy,
    output logic              res_valid,
    input  logic              res_take,
    output gsp_pkg::out_item_t res_data
);

    localparam logic [ADC_BITS-1:0] FULL = '1;

    gsp_pkg::state_t state_reg, state_next;

    logic [1:0]                 log_idx_reg, log_idx_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic [ADC_BITS-1:0]        a_reg, a_next;
    logic                       sat_reg, sat_next;
    logic                       cal_reg, cal_next;
    logic [gsp_pkg::MANT_W-1:0] m_reg, m_next;
    logic [gsp_pkg::FRAC_W-1:0] frac_reg, frac_next;
    logic [4:0]                 p_reg, p_next;
    logic [gsp_pkg::LOG_W-1:0]  la_reg, la_next;
    logic signed [21:0]         lrs_reg, lrs_next;
    logic signed [21:0]         lscale_reg, lscale_next;
    logic [16:0]                rem_reg, rem_next;
    logic [35:0]                quo_reg, quo_next;
    logic                       neg_reg, neg_next;
    logic signed [23:0]         l0_reg, l0_next;
    logic                       l0_valid_reg, l0_valid_next;
    logic [31:0]                r_reg, r_next;
    logic [gsp_pkg::FRAC_W-1:0] f_reg, f_next;
    logic signed [14:0]         ip_reg, ip_next;
    logic [gsp_pkg::PPM_W-1:0]  ppm_reg, ppm_next;

    // Input sample, masked to the converter width and clamped off the rails
    logic [ADC_BITS+11:0] adc_ext;
    logic [ADC_BITS-1:0]  adc_in;
    logic [ADC_BITS-1:0]  adc_clamped;
    logic                 adc_rail;
    logic                 cal_cond;

    always_comb
    begin
        adc_ext     = {{ADC_BITS{1'b0}}, in_data.adc_sample};
        adc_in      = adc_ext[ADC_BITS-1:0];
        adc_rail    = (adc_in == '0) || (adc_in == FULL);
        adc_clamped = (adc_in == '0) ? ADC_BITS'(1) :
                      (adc_in == FULL) ? FULL - ADC_BITS'(1) : adc_in;
        cal_cond    = ({16'd0, in_data.uptime_ms} < {32'd0, cfg.cal_window_ms}) &&
                      (cfg.curve_scale != '0) && (cfg.curve_exponent != '0);
    end

    // Log unit operand select and leading-one search
    logic [ADC_BITS-1:0]           rdiff;
    logic [gsp_pkg::LOG_IN_W-1:0]  log_x;
    logic [4:0]                    lead;

    always_comb
    begin
        rdiff = FULL - a_reg;
        case (log_idx_reg)
            2'd0:    log_x = gsp_pkg::LOG_IN_W'({rdiff, 2'b00}) +
                             gsp_pkg::LOG_IN_W'(rdiff);
            2'd1:    log_x = gsp_pkg::LOG_IN_W'(a_reg);
            2'd2:    log_x = cfg.curve_scale;
            default: log_x = gsp_pkg::CAL_PPM;
        endcase
        lead = '0;
        for (int i = 0; i < gsp_pkg::LOG_IN_W; i++)
        begin
            if (log_x[i]) lead = 5'(i);
        end
    end

    // Shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    always_comb
    begin
        case (state_reg)
            gsp_pkg::ST_LOG_SQ:
            begin
                mul_a = $signed({2'b00, m_reg});
                mul_b = $signed({2'b00, m_reg});
            end
            gsp_pkg::ST_LP:
            begin
                mul_a = 33'(cfg.curve_exponent);
                mul_b = 33'(26'(lrs_reg) - 26'(l0_reg));
            end
            gsp_pkg::ST_EXP:
            begin
                mul_a = $signed({1'b0, r_reg});
                mul_b = $signed({1'b0, gsp_pkg::EXP_C[cnt_reg[3:0]]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Derived values used by the log, divide, power-law and rounding steps
    logic [31:0]               sq;
    logic [gsp_pkg::MANT_W-1:0] sq_m;
    logic                      sq_bit;
    logic [gsp_pkg::FRAC_W-1:0] frac_upd;
    logic [gsp_pkg::LOG_W-1:0] log_val;
    logic signed [22:0]        dlog;
    logic [22:0]               dmag;
    logic [16:0]               emag_w;
    logic [15:0]               emag;
    logic [16:0]               div_t;
    logic                      div_ge;
    logic [16:0]               rem_upd;
    logic [35:0]               quo_upd;
    logic signed [37:0]        qs;
    logic signed [37:0]        l0_wide;
    logic signed [23:0]        l0_sat;
    logic signed [29:0]        prod_fl;
    logic signed [30:0]        lp;
    logic signed [14:0]        lp_ip;
    logic [4:0]                shamt;
    logic [32:0]               rsum;
    logic [32:0]               rshift;

    always_comb
    begin
        sq       = mul_p[61:30];
        sq_bit   = sq[31];
        sq_m     = sq_bit ? sq[31:1] : sq[30:0];
        frac_upd = {frac_reg[14:0], sq_bit};
        log_val  = {p_reg, frac_upd};
        dlog     = 23'($signed({1'b0, log_val})) - 23'(lscale_reg);
        dmag     = dlog[22] ? 23'(-dlog) : dlog;
        emag_w   = cfg.curve_exponent[15] ? 17'(-18'(cfg.curve_exponent)) :
                                           17'(cfg.curve_exponent);
        emag     = emag_w[15:0];
        div_t    = {rem_reg[15:0], quo_reg[35]};
        div_ge   = div_t >= {1'b0, emag};
        rem_upd  = div_ge ? div_t - {1'b0, emag} : div_t;
        quo_upd  = {quo_reg[34:0], div_ge};
        qs       = neg_reg ? -$signed({2'b00, quo_upd}) : $signed({2'b00, quo_upd});
        l0_wide  = 38'(lrs_reg) - qs;
        if (l0_wide > gsp_pkg::LOG0_MAX)      l0_sat = 24'(gsp_pkg::LOG0_MAX);
        else if (l0_wide < gsp_pkg::LOG0_MIN) l0_sat = 24'(gsp_pkg::LOG0_MIN);
        else                                  l0_sat = l0_wide[23:0];
        prod_fl  = mul_p[41:12];
        lp       = 31'(lscale_reg) + 31'(prod_fl);
        lp_ip    = lp[30:16];
        shamt    = 5'd30 - 5'(ip_reg);
        rsum     = {1'b0, r_reg} + (33'd1 << (shamt - 5'd1));
        rshift   = rsum >> shamt;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gsp_pkg::ST_IDLE:
                if (start) state_next = gsp_pkg::ST_LOG_NORM;
            gsp_pkg::ST_LOG_NORM:
                state_next = gsp_pkg::ST_LOG_SQ;
            gsp_pkg::ST_LOG_SQ:
                if (cnt_reg == 6'(gsp_pkg::SQ_STEPS - 1))
                begin
                    if (log_idx_reg != 2'd3)  state_next = gsp_pkg::ST_LOG_NORM;
                    else if (cal_reg)         state_next = gsp_pkg::ST_DIV;
                    else if (l0_valid_reg && cfg.curve_scale != '0)
                                              state_next = gsp_pkg::ST_LP;
                    else                      state_next = gsp_pkg::ST_DONE;
                end
            gsp_pkg::ST_DIV:
                if (cnt_reg == 6'(gsp_pkg::DIV_STEPS - 1)) state_next = gsp_pkg::ST_LP;
            gsp_pkg::ST_LP:
                if (lp_ip >= 15'sd20 || lp_ip < -15'sd1) state_next = gsp_pkg::ST_DONE;
                else                                     state_next = gsp_pkg::ST_EXP;
            gsp_pkg::ST_EXP:
                if (cnt_reg == 6'(gsp_pkg::SQ_STEPS - 1)) state_next = gsp_pkg::ST_ROUND;
            gsp_pkg::ST_ROUND:
                state_next = gsp_pkg::ST_DONE;
            gsp_pkg::ST_DONE:
                if (res_take) state_next = gsp_pkg::ST_IDLE;
            default:
                state_next = gsp_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates
    always_comb
    begin
        log_idx_next  = log_idx_reg;
        cnt_next      = cnt_reg;
        a_next        = a_reg;
        sat_next      = sat_reg;
        cal_next      = cal_reg;
        m_next        = m_reg;
        frac_next     = frac_reg;
        p_next        = p_reg;
        la_next       = la_reg;
        lrs_next      = lrs_reg;
        lscale_next   = lscale_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        neg_next      = neg_reg;
        l0_next       = l0_reg;
        l0_valid_next = l0_valid_reg;
        r_next        = r_reg;
        f_next        = f_reg;
        ip_next       = ip_reg;
        ppm_next      = ppm_reg;
        case (state_reg)
            gsp_pkg::ST_IDLE:
                if (start)
                begin
                    a_next       = adc_clamped;
                    sat_next     = adc_rail;
                    cal_next     = cal_cond;
                    log_idx_next = 2'd0;
                    ppm_next     = '0;
                end
            gsp_pkg::ST_LOG_NORM:
            begin
                p_next    = lead;
                m_next    = gsp_pkg::MANT_W'({7'd0, log_x} << (5'd30 - lead));
                frac_next = '0;
                cnt_next  = '0;
            end
            gsp_pkg::ST_LOG_SQ:
            begin
                m_next    = sq_m;
                frac_next = frac_upd;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'(gsp_pkg::SQ_STEPS - 1))
                begin
                    log_idx_next = log_idx_reg + 2'd1;
                    cnt_next     = '0;
                    case (log_idx_reg)
                        2'd0:    la_next     = log_val;
                        2'd1:    lrs_next    = $signed({1'b0, la_reg}) -
                                               $signed({1'b0, log_val});
                        2'd2:    lscale_next = $signed({1'b0, log_val}) -
                                               gsp_pkg::SCALE_OFS;
                        default:
                        begin
                            rem_next = '0;
                            quo_next = {1'b0, dmag, 12'd0};
                            neg_next = dlog[22] ^ cfg.curve_exponent[15];
                        end
                    endcase
                end
            end
            gsp_pkg::ST_DIV:
            begin
                rem_next = rem_upd;
                quo_next = quo_upd;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(gsp_pkg::DIV_STEPS - 1))
                begin
                    l0_next       = l0_sat;
                    l0_valid_next = 1'b1;
                end
            end
            gsp_pkg::ST_LP:
            begin
                r_next   = 32'd1 << 30;
                f_next   = lp[15:0];
                ip_next  = lp_ip;
                cnt_next = '0;
                if (lp_ip >= 15'sd20)
                begin
                    ppm_next = gsp_pkg::PPM_MAX;
                    sat_next = 1'b1;
                end
            end
            gsp_pkg::ST_EXP:
            begin
                if (f_reg[4'd15 - cnt_reg[3:0]]) r_next = mul_p[61:30];
                cnt_next = cnt_reg + 6'd1;
            end
            gsp_pkg::ST_ROUND:
                if (rshift > 33'(gsp_pkg::PPM_MAX))
                begin
                    ppm_next = gsp_pkg::PPM_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    ppm_next = rshift[gsp_pkg::PPM_W-1:0];
                end
            default:
            begin
            end
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gsp_pkg::ST_IDLE;
            l0_reg       <= '0;
            l0_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            l0_reg       <= l0_next;
            l0_valid_reg <= l0_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        log_idx_reg <= log_idx_next;
        cnt_reg     <= cnt_next;
        a_reg       <= a_next;
        sat_reg     <= sat_next;
        cal_reg     <= cal_next;
        m_reg       <= m_next;
        frac_reg    <= frac_next;
        p_reg       <= p_next;
        la_reg      <= la_next;
        lrs_reg     <= lrs_next;
        lscale_reg  <= lscale_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        neg_reg     <= neg_next;
        r_reg       <= r_next;
        f_reg       <= f_next;
        ip_reg      <= ip_next;
        ppm_reg     <= ppm_next;
    end

    // Outputs
    always_comb
    begin
        busy                 = state_reg != gsp_pkg::ST_IDLE;
        res_valid            = state_reg == gsp_pkg::ST_DONE;
        res_data.ppm         = ppm_reg;
        res_data.saturated   = sat_reg;
        res_data.calibrating = cal_reg;
        res_data.calibrated  = l0_valid_reg;
    end

endmodule

// ===== sv/gsp_checker.sv =====
// Port-level checks for the gas sensor ppm converter, bound to the top level.
module gsp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input gsp_pkg::out_item_t out_data
);

    // A sample in work blocks the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a transaction");

    // A waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    // Recalibration implies a stored clean-air value
    a_cal_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.calibrating) |-> out_data.calibrated)
        else $error("calibrating without calibrated");

    // No reading without calibration
    a_uncal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.calibrated) |-> (out_data.ppm == '0))
        else $error("ppm given while uncalibrated");

endmodule

bind gas_sensor_ppm_converter gsp_checker u_gsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
